FILE: src/jev_pkg.sv
// ============================================================================
// jev_pkg
// Shared types and constants for the joystick event to key code translator.
// ============================================================================
`default_nettype none

package jev_pkg;

    localparam int AXES   = 16;
    localparam int SLOT_W = $clog2(AXES);

    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    localparam logic [14:0] DEAD_ZONE_RESET = 15'd6540;
    localparam logic [10:0] BUTTON_FLAG     = 11'h400;
    localparam logic [3:0]  SLOT_MASK       = 4'hF;

    localparam logic [0:0] REG_DEAD_ZONE = 1'b0;

    localparam logic [1:0] KIND_BUTTON = 2'd0;
    localparam logic [1:0] KIND_AXIS   = 2'd1;

    typedef struct packed {
        logic [1:0]          kind;
        logic [7:0]          number;
        logic signed [15:0]  level;
    } item_t;

    typedef struct packed {
        logic        pressed;
        logic [10:0] code;
    } result_t;

    typedef struct packed {
        logic               wr;
        logic [SLOT_W-1:0]  slot;
        logic [9:0]         held;
        logic signed [15:0] kept;
    } axis_upd_t;

endpackage

`default_nettype wire

FILE: src/jev_if.sv
// ============================================================================
// jev_if
// Valid/ready stream interfaces for joystick events and key code results.
// ============================================================================
`default_nettype none

interface jev_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [7:0]         number;
    logic signed [15:0] level;

    modport source (output valid, kind, number, level, input ready);
    modport sink   (input valid, kind, number, level, output ready);
endinterface

interface jev_out_if;
    logic        valid;
    logic        ready;
    logic        pressed;
    logic [10:0] code;

    modport source (output valid, pressed, code, input ready);
    modport sink   (input valid, pressed, code, output ready);
endinterface

`default_nettype wire

FILE: src/jev_apb_regs.sv
// ============================================================================
// jev_apb_regs
// APB-style configuration register holding the dead zone half-width.
// ============================================================================
`default_nettype none

module jev_apb_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [jev_pkg::PADDR_W-1:0] paddr,
    input  wire logic [jev_pkg::DATA_W-1:0]  pwdata,
    output logic      [jev_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,
    output logic      [14:0]                 dead_zone
);

    logic [14:0] dead_zone_reg;
    logic [14:0] dead_zone_next;
    logic        hit_dead_zone;

    assign pready        = 1'b1;
    assign hit_dead_zone = (paddr[jev_pkg::PADDR_W-1:2] == jev_pkg::REG_DEAD_ZONE);

    always_comb
    begin
        dead_zone_next = dead_zone_reg;
        if (psel && penable && pwrite && pready && hit_dead_zone)
        begin
            dead_zone_next = pwdata[14:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg <= jev_pkg::DEAD_ZONE_RESET;
        end
        else
        begin
            dead_zone_reg <= dead_zone_next;
        end
    end

    assign prdata    = hit_dead_zone ? {{(jev_pkg::DATA_W-15){1'b0}}, dead_zone_reg}
                                     : '0;
    assign dead_zone = dead_zone_reg;

endmodule

`default_nettype wire

FILE: src/jev_axis_state.sv
// ============================================================================
// jev_axis_state
// Per-axis held key code and last kept level, read and updated once a cycle.
// ============================================================================
`default_nettype none

module jev_axis_state (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [jev_pkg::SLOT_W-1:0] rd_slot,
    output logic      [9:0]                 rd_held,
    output logic signed [15:0]              rd_kept,
    input  wire jev_pkg::axis_upd_t         upd
);

    logic [jev_pkg::AXES-1:0][9:0]         held_reg;
    logic [jev_pkg::AXES-1:0][9:0]         held_next;
    logic [jev_pkg::AXES-1:0][15:0]        kept_reg;
    logic [jev_pkg::AXES-1:0][15:0]        kept_next;

    always_comb
    begin
        held_next = held_reg;
        kept_next = kept_reg;
        if (upd.wr)
        begin
            held_next[upd.slot] = upd.held;
            kept_next[upd.slot] = upd.kept;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            kept_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
            kept_reg <= kept_next;
        end
    end

    assign rd_held = held_reg[rd_slot];
    assign rd_kept = signed'(kept_reg[rd_slot]);

endmodule

`default_nettype wire

FILE: src/jev_xlate.sv
// ============================================================================
// jev_xlate
// Translate one event into an optional key beat and an axis state update.
// ============================================================================
`default_nettype none

module jev_xlate (
    input  wire jev_pkg::item_t             item,
    input  wire logic [14:0]                dead_zone,
    input  wire logic [9:0]                 held,
    input  wire logic signed [15:0]         kept,
    output logic      [jev_pkg::SLOT_W-1:0] slot,
    output logic                            has_result,
    output jev_pkg::result_t                result,
    output jev_pkg::axis_upd_t              upd
);

    logic signed [17:0] lvl_w;
    logic signed [17:0] dz_w;
    logic signed [17:0] snap_w;
    logic signed [17:0] kept_w;
    logic signed [15:0] snapped;
    logic               in_center;
    logic               in_band;
    logic [9:0]         press_code;
    logic [9:0]         axis_code;

    assign slot = jev_pkg::SLOT_W'(({1'b0, item.number[3:0] & jev_pkg::SLOT_MASK})
                                   % 5'(jev_pkg::AXES));

    assign lvl_w     = 18'(item.level);
    assign dz_w      = signed'({3'b000, dead_zone});
    assign in_center = (lvl_w < dz_w) && (lvl_w > -dz_w);
    assign snapped   = in_center ? 16'sd0 : item.level;

    assign snap_w  = 18'(snapped);
    assign kept_w  = 18'(kept);
    assign in_band = (snap_w < kept_w + dz_w) && (snap_w > kept_w - dz_w);

    assign press_code = {1'b0, item.number, 1'b0} + 10'd1
                        + {9'd0, (snapped > 16'sd0)};
    assign axis_code  = (snapped != 16'sd0) ? press_code : held;

    always_comb
    begin
        has_result     = 1'b0;
        result.pressed = 1'b0;
        result.code    = '0;
        upd.wr         = 1'b0;
        upd.slot       = slot;
        upd.held       = '0;
        upd.kept       = snapped;
        priority if (item.kind == jev_pkg::KIND_AXIS)
        begin
            if (!in_band)
            begin
                upd.wr         = 1'b1;
                upd.held       = (snapped != 16'sd0) ? press_code : 10'd0;
                result.pressed = (snapped != 16'sd0);
                result.code    = {1'b0, axis_code};
                has_result     = (axis_code != 10'd0);
            end
        end
        else if (item.kind == jev_pkg::KIND_BUTTON)
        begin
            result.pressed = (item.level == 16'sd1);
            result.code    = {3'b000, item.number} | jev_pkg::BUTTON_FLAG;
            has_result     = (item.level == 16'sd0) || (item.level == 16'sd1);
        end
        else
        begin
            has_result = 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: src/joystick_event_to_key_code.sv
// ============================================================================
// joystick_event_to_key_code
// Turn joystick axis and button events into key press and release codes.
//
//   Port      Dir  Kind          Payload
//   in_ch     in   valid/ready   kind[1:0] number[7:0] level[15:0] signed
//   out_ch    out  valid/ready   pressed code[10:0]
//   apb       in   APB write/rd  dead_zone at byte address 0
//
// One event per cycle while out_ch does not stall; each event is held in the
// input register, and any beat it makes then goes to the result register.
// Axis state is updated as the event leaves the input register, so the next
// event already sees it. Events that give no beat move on even while out_ch
// stalls; reset clears the dead zone to 6540 and all axis state to zero.
// ============================================================================
`default_nettype none

module joystick_event_to_key_code (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    jev_in_if.sink                           in_ch,
    jev_out_if.source                        out_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [jev_pkg::PADDR_W-1:0] paddr,
    input  wire logic [jev_pkg::DATA_W-1:0]  pwdata,
    output logic      [jev_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    logic                       s1_valid_reg;
    logic                       s1_valid_next;
    jev_pkg::item_t             s1_item_reg;
    logic                       res_valid_reg;
    logic                       res_valid_next;
    jev_pkg::result_t           res_reg;

    logic [14:0]                dead_zone;
    logic [jev_pkg::SLOT_W-1:0] slot;
    logic [9:0]                 held;
    logic signed [15:0]         kept;
    logic                       has_result;
    jev_pkg::result_t           result;
    jev_pkg::axis_upd_t         upd;
    jev_pkg::axis_upd_t         upd_gated;
    logic                       consume;
    logic                       take;

    jev_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .dead_zone (dead_zone)
    );

    jev_xlate u_xlate (
        .item       (s1_item_reg),
        .dead_zone  (dead_zone),
        .held       (held),
        .kept       (kept),
        .slot       (slot),
        .has_result (has_result),
        .result     (result),
        .upd        (upd)
    );

    always_comb
    begin
        upd_gated    = upd;
        upd_gated.wr = upd.wr && consume;
    end

    jev_axis_state u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_slot (slot),
        .rd_held (held),
        .rd_kept (kept),
        .upd     (upd_gated)
    );

    // advance the input register when the result slot is free or no beat is made
    assign consume     = s1_valid_reg && (!res_valid_reg || out_ch.ready || !has_result);
    assign in_ch.ready = !s1_valid_reg || consume;
    assign take        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (consume)
        begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (consume && has_result)
        begin
            res_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_item_reg.kind   <= in_ch.kind;
            s1_item_reg.number <= in_ch.number;
            s1_item_reg.level  <= in_ch.level;
        end
        if (consume && has_result)
        begin
            res_reg <= result;
        end
    end

    assign out_ch.valid   = res_valid_reg;
    assign out_ch.pressed = res_reg.pressed;
    assign out_ch.code    = res_reg.code;

    a_beat_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(s1_valid_reg))
        else $error("result beat appeared without a staged event");

    a_code_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.code != 11'd0))
        else $error("key code zero delivered");

    a_button_code: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.code[10]) |-> (res_reg.code[9:8] == 2'b00))
        else $error("button code out of range");

    a_no_state_write_other: assert property (@(posedge clk) disable iff (!rst_n)
        (upd_gated.wr) |-> (s1_item_reg.kind == jev_pkg::KIND_AXIS))
        else $error("axis state written by a non-axis event");

endmodule

`default_nettype wire
